[hw/rtl/u16u8_pkg.sv]
// Shared types, constants and the UTF-8 byte encoder for the UTF-16 to UTF-8 block.
// No dependencies; every module of the block imports this package.
package u16u8_pkg;

	localparam logic [15:0] HI_MIN = 16'hD800;
	localparam logic [15:0] HI_MAX = 16'hDBFF;
	localparam logic [15:0] LO_MIN = 16'hDC00;
	localparam logic [15:0] LO_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE = 21'h10000;
	localparam logic [5:0] HI_PREFIX = 6'b110110;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] ADDR_STRICT = 3'd0;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_ILLEGAL   = 2'd2
	} status_e;

	// Work for the back end: up to two code points, then an optional status result.
	typedef struct packed {
		logic [20:0] cp_a;
		logic [2:0]  a_cnt;
		logic [15:0] cp_b;
		logic [1:0]  b_cnt;
		logic        stat_en;
		status_e     stat;
		logic        str_last;
	} job_t;

	// Byte idx of the len-byte UTF-8 form of cp.
	function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [2:0] len, logic [2:0] idx);
		logic [7:0] b;
		b = {2'b10, cp[5:0]};
		case (len)
			3'd1: b = {1'b0, cp[6:0]};
			3'd2: b = (idx == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			3'd3: begin
				case (idx)
					3'd0: b = {4'b1110, cp[15:12]};
					3'd1: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd4: begin
				case (idx)
					3'd0: b = {5'b11110, cp[20:18]};
					3'd1: b = {2'b10, cp[17:12]};
					3'd2: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = {2'b10, cp[5:0]};
		endcase
		return b;
	endfunction

endpackage

[hw/rtl/utf16_to_utf8_encoder_top.sv]
// UTF-16 to UTF-8 encoder: one code unit in per transfer, one UTF-8 byte or status out per transfer.
// After the unit is accepted, its first result passes through the queue, then the output register.
// The back end emits one result per cycle while out_ready does not stall it; a unit yields 1 to 6
// results by its job; units with no result push no job. Input runs ahead by the queue depth.
// Reset clears surrogate/discard state, the queue, the output register and strict_mode.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
module utf16_to_utf8_encoder_top import u16u8_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic        string_last,
	output logic [1:0]  status
);

	logic strict_q;
	logic fire;
	logic push;
	logic pop;
	logic full;
	logic head_valid;
	job_t wr_job;
	job_t head_job;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_STRICT) ? {31'b0, strict_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr == ADDR_STRICT)) begin
			strict_q <= pwdata[0];
		end
	end

	assign in_ready = !full;
	assign fire     = in_valid && in_ready;

	u16u8_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.strict_mode (strict_q),
		.fire        (fire),
		.code_unit   (code_unit),
		.last_unit   (last_unit),
		.push        (push),
		.job         (wr_job)
	);

	u16u8_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_job     (wr_job),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	u16u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.run_last    (run_last),
		.string_last (string_last),
		.status      (status)
	);

endmodule

[hw/rtl/u16u8_front.sv]
// Front end: accepts code units, tracks surrogate pairing and discard state,
// and turns each unit with a result into a job for the back end. Depends on u16u8_pkg.
module u16u8_front import u16u8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        strict_mode,
	input  logic        fire,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        push,
	output job_t        job
);

	logic       pend_q, pend_d;
	logic [9:0] hb_q, hb_d;
	logic       disc_q, disc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			hb_q   <= '0;
			disc_q <= 1'b0;
		end else begin
			pend_q <= pend_d;
			hb_q   <= hb_d;
			disc_q <= disc_d;
		end
	end

	always_comb begin
		logic is_high;
		logic is_low;
		logic done;
		logic err;
		is_high = code_unit inside {[HI_MIN:HI_MAX]};
		is_low  = code_unit inside {[LO_MIN:LO_MAX]};
		done    = 1'b0;
		err     = 1'b0;
		pend_d  = pend_q;
		hb_d    = hb_q;
		disc_d  = disc_q;
		job     = '0;
		job.stat = ST_OK;
		push    = 1'b0;
		if (fire) begin
			if (disc_q) begin
				if (last_unit) begin
					disc_d = 1'b0;
				end
			end else begin
				if (pend_q) begin
					pend_d = 1'b0;
					if (is_low) begin
						job.cp_a  = {1'b0, hb_q, code_unit[9:0]} + SUPP_BASE;
						job.a_cnt = 3'd4;
						done = 1'b1;
					end else if (strict_mode) begin
						job.stat_en = 1'b1;
						job.stat    = ST_ILLEGAL;
						err  = 1'b1;
						done = 1'b1;
					end else begin
						job.cp_a  = {5'b0, HI_PREFIX, hb_q};
						job.a_cnt = 3'd3;
					end
				end
				if (!done) begin
					if (is_high) begin
						if (last_unit) begin
							job.stat_en = 1'b1;
							job.stat    = ST_EXHAUSTED;
						end else begin
							pend_d = 1'b1;
							hb_d   = code_unit[9:0];
						end
					end else if (is_low && strict_mode) begin
						job.stat_en = 1'b1;
						job.stat    = ST_ILLEGAL;
						err = 1'b1;
					end else begin
						job.cp_b = code_unit;
						if (code_unit < 16'h0080) begin
							job.b_cnt = 2'd1;
						end else if (code_unit < 16'h0800) begin
							job.b_cnt = 2'd2;
						end else begin
							job.b_cnt = 2'd3;
						end
					end
				end
				job.str_last = last_unit || err;
				push = (job.a_cnt != 3'd0) || (job.b_cnt != 2'd0) || job.stat_en;
				if (err && !last_unit) begin
					disc_d = 1'b1;
				end
			end
		end
	end

endmodule

[hw/rtl/u16u8_queue.sv]
// Job queue between front and back end, a small register FIFO.
// Depends on u16u8_pkg for the job type.
module u16u8_queue import u16u8_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full       = (cnt_q == CntFull);
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/u16u8_back.sv]
// Back end: walks the head job one result per cycle, while the output is not stalled, into the output register.
// Depends on u16u8_pkg for the job type and the byte encoder.
module u16u8_back import u16u8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       string_last,
	output logic [1:0] status
);

	logic [2:0] k_q;
	logic       ov_q;
	logic [7:0] byte_q;
	logic       bv_q, rl_q, sl_q;
	logic [1:0] st_q;

	logic [2:0] n_res;
	logic [2:0] b_end;
	logic [2:0] b_idx;
	logic       is_last;
	logic       load;
	logic [7:0] byte_d;
	logic       bv_d;
	logic [1:0] st_d;

	assign b_end   = head_job.a_cnt + {1'b0, head_job.b_cnt};
	assign n_res   = b_end + {2'b0, head_job.stat_en};
	assign b_idx   = k_q - head_job.a_cnt;
	assign is_last = (k_q == n_res - 3'd1);
	assign load    = head_valid && (!ov_q || out_ready);
	assign pop     = load && is_last;

	always_comb begin
		byte_d = '0;
		bv_d   = 1'b0;
		st_d   = ST_OK;
		if (k_q < head_job.a_cnt) begin
			byte_d = utf8_byte(head_job.cp_a, head_job.a_cnt, k_q);
			bv_d   = 1'b1;
		end else if (k_q < b_end) begin
			byte_d = utf8_byte({5'b0, head_job.cp_b}, {1'b0, head_job.b_cnt}, b_idx);
			bv_d   = 1'b1;
		end else begin
			st_d = head_job.stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (pop) begin
				k_q <= '0;
			end else if (load) begin
				k_q <= k_q + 3'd1;
			end
		end
	end

	// Payload of the output register; hold while the consumer stalls.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			bv_q   <= bv_d;
			rl_q   <= is_last;
			sl_q   <= is_last && head_job.str_last;
			st_q   <= st_d;
		end
	end

	assign out_valid   = ov_q;
	assign out_byte    = byte_q;
	assign byte_valid  = bv_q;
	assign run_last    = rl_q;
	assign string_last = sl_q;
	assign status      = st_q;

endmodule
